// ----- hdl/toroid_surface_normal_defines.svh -----
// Assertion macros for the toroid surface normal block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TOROID_SURFACE_NORMAL_DEFINES_SVH
`define TOROID_SURFACE_NORMAL_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TSN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define TSN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tsn_pkg.sv -----
// Shared constants for the toroid surface normal pipeline.
// No dependencies; used by all modules through scoped names.
`timescale 1ns / 1ps
`default_nettype none
package tsn_pkg;

  // Configuration register indexes
  localparam logic REG_MAJOR_RADIUS = 1'b0;
  localparam logic REG_MINOR_RADIUS = 1'b1;

  // Field and datapath widths
  localparam int COORD_W  = 48;
  localparam int NORM_W   = 32;
  localparam int MUL_W    = 64;
  localparam int RAD_W    = 128;
  localparam int ROOT_W   = 64;
  localparam int REM_W    = ROOT_W + 2;
  localparam int MAG_BITS = 62;
  localparam int QUO_W    = 31;
  localparam int DIVR_W   = 64;
  localparam int DEN_W    = 63;

  // Iteration counts of the cell chains
  localparam int SQ1_STEPS = 49;
  localparam int SQ2_STEPS = 63;
  localparam int DIV_STEPS = QUO_W;

  // Pipeline stage numbers
  localparam int ST_SQ1_IN  = 5;
  localparam int ST_SQ1_OUT = ST_SQ1_IN + SQ1_STEPS;
  localparam int FRONT_DLY  = ST_SQ1_OUT - 2;
  localparam int ST_SHIFT   = ST_SQ1_OUT + 6;
  localparam int ST_SQ2_IN  = ST_SHIFT + 3;
  localparam int ST_SQ2_OUT = ST_SQ2_IN + SQ2_STEPS;
  localparam int BACK_DLY   = ST_SQ2_OUT - ST_SHIFT;
  localparam int ST_DIV_OUT = ST_SQ2_OUT + DIV_STEPS;
  localparam int PIPE_DEPTH = ST_DIV_OUT + 1;

endpackage
`default_nettype wire

// ----- hdl/tsn_mul.sv -----
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on tsn_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module tsn_mul (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [tsn_pkg::MUL_W-1:0]      a_i,
  input  wire logic [tsn_pkg::MUL_W-1:0]      b_i,
  output logic      [2*tsn_pkg::MUL_W-1:0]    prod_o
);

  localparam int HW = tsn_pkg::MUL_W / 2;

  logic [2*HW-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [2*tsn_pkg::MUL_W-1:0] prod_r;

  // Form partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= a_i[HW-1:0] * b_i[HW-1:0];
      pp01_r <= a_i[HW-1:0] * b_i[2*HW-1:HW];
      pp10_r <= a_i[2*HW-1:HW] * b_i[HW-1:0];
      pp11_r <= a_i[2*HW-1:HW] * b_i[2*HW-1:HW];
    end
  end

  // Combine partial products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {pp11_r, pp00_r}
              + {{(HW-1){1'b0}}, {1'b0, pp01_r} + {1'b0, pp10_r}, {HW{1'b0}}};
    end
  end

  assign prod_o = prod_r;

endmodule
`default_nettype wire

// ----- hdl/tsn_sqrt_cell.sv -----
// One digit of a digit-by-digit integer square root; chained per result bit.
// Depends on tsn_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module tsn_sqrt_cell (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [tsn_pkg::RAD_W-1:0]     rad_i,
  input  wire logic [tsn_pkg::ROOT_W-1:0]    root_i,
  input  wire logic [tsn_pkg::REM_W-1:0]     rem_i,
  output logic      [tsn_pkg::RAD_W-1:0]     rad_o,
  output logic      [tsn_pkg::ROOT_W-1:0]    root_o,
  output logic      [tsn_pkg::REM_W-1:0]     rem_o
);

  logic [tsn_pkg::REM_W-1:0] rem_sh, trial, rem_nxt;
  logic                      ge;
  logic [tsn_pkg::RAD_W-1:0]  rad_r;
  logic [tsn_pkg::ROOT_W-1:0] root_r;
  logic [tsn_pkg::REM_W-1:0]  rem_r;

  // Bring down the next two radicand bits and try the new root bit
  always_comb begin
    rem_sh  = {rem_i[tsn_pkg::REM_W-3:0], rad_i[tsn_pkg::RAD_W-1 -: 2]};
    trial   = {root_i, 2'b01};
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  // Hand the partial root and remainder to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[tsn_pkg::RAD_W-3:0], 2'b00};
      root_r <= {root_i[tsn_pkg::ROOT_W-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;

endmodule
`default_nettype wire

// ----- hdl/tsn_div_cell.sv -----
// One quotient bit of a restoring divider; chained per quotient bit.
// Depends on tsn_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module tsn_div_cell (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [tsn_pkg::DIVR_W-1:0]    rem_i,
  input  wire logic [tsn_pkg::DEN_W-1:0]     den_i,
  input  wire logic [tsn_pkg::QUO_W-1:0]     quo_i,
  output logic      [tsn_pkg::DIVR_W-1:0]    rem_o,
  output logic      [tsn_pkg::DEN_W-1:0]     den_o,
  output logic      [tsn_pkg::QUO_W-1:0]     quo_o
);

  logic [tsn_pkg::DIVR_W-1:0] den_ext, diff;
  logic                       ge;
  logic [tsn_pkg::DIVR_W-1:0] rem_r;
  logic [tsn_pkg::DEN_W-1:0]  den_r;
  logic [tsn_pkg::QUO_W-1:0]  quo_r;

  // Compare and subtract; the remainder stays below the divisor
  always_comb begin
    den_ext = {1'b0, den_i};
    ge      = (rem_i >= den_ext);
    diff    = ge ? (rem_i - den_ext) : rem_i;
  end

  // Double the remainder for the next bit
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= {diff[tsn_pkg::DIVR_W-2:0], 1'b0};
      den_r <= den_i;
      quo_r <= {quo_i[tsn_pkg::QUO_W-2:0], ge};
    end
  end

  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;

endmodule
`default_nettype wire

// ----- hdl/toroid_surface_normal.sv -----
// Top level of the toroid surface normal pipeline.
// Depends on tsn_pkg, tsn_mul, tsn_sqrt_cell, tsn_div_cell and the defines header.
//
// Channel  Dir  Handshake           Carries
// cfg      in   cfg_we              major_radius / minor_radius
// in       in   in_tvalid/tready    hit_x, hit_y, hit_z, last_ray
// out      out  out_tvalid/tready   normal_x/y/z, degenerate, last_out
//
// One hit point enters per cycle while the skid register is empty; each result
// passes through the two square-root cell chains (49 and 63 cells) and
// the 31-cell divider chains. Reset clears all valid bits and loads both radii
// with 1.0. The whole pipeline freezes only while the skid register holds a
// result; in_tready is that register's empty flag.
`timescale 1ns / 1ps
`default_nettype none
`include "toroid_surface_normal_defines.svh"
module toroid_surface_normal (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [47:0]  cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,   // hit_x, hit_y, hit_z
  input  wire logic         in_tlast,   // last_ray
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // normal_x, normal_y, normal_z
  output logic [0:0]        out_tuser,  // degenerate
  output logic              out_tlast   // last_out
);

  localparam int CW = tsn_pkg::COORD_W;
  localparam int MW = tsn_pkg::MUL_W;
  localparam int PW = 2 * tsn_pkg::MUL_W;
  localparam int NW = tsn_pkg::NORM_W;
  localparam int QW = tsn_pkg::QUO_W;
  localparam int GB = tsn_pkg::MAG_BITS;

  typedef struct packed {
    logic                 sx, sa, sz, last;
    logic [CW-1:0]        ax;
    logic [CW:0]          aa;
    logic [CW-1:0]        az;
    logic signed [CW:0]   k;
  } front_t;

  typedef struct packed {
    logic sx, sa, sz, nm, last, deg;
  } mid_t;

  typedef struct packed {
    logic [GB-1:0] p, q, s;
    mid_t          mid;
  } back_t;

  typedef struct packed {
    logic [NW-1:0] nx, ny, nz;
    logic          deg, last;
  } res_t;

  logic signed [CW-1:0] major_r, minor_r;
  logic en, acc;
  logic [tsn_pkg::PIPE_DEPTH:1] vld_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r <= 48'sd16777216;
      minor_r <= 48'sd16777216;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsn_pkg::REG_MAJOR_RADIUS: major_r <= cfg_data;
        tsn_pkg::REG_MINOR_RADIUS: minor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic skid_v_r, out_v_r;
  res_t skid_r, out_r, res_r;

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  // Advance the valid line
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[tsn_pkg::PIPE_DEPTH-1:1], acc};
  end

  // Stage 1: offsets from the torus center
  logic signed [CW-1:0] x1_r, z1_r;
  logic signed [CW:0]   a1_r, k1_r;
  logic                 last1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= in_tdata[CW-1:0];
      z1_r    <= in_tdata[3*CW-1:2*CW];
      a1_r    <= {in_tdata[2*CW-1], in_tdata[2*CW-1:CW]} - {major_r[CW-1], major_r};
      k1_r    <= {major_r[CW-1], major_r} - {minor_r[CW-1], minor_r};
      last1_r <= in_tlast;
    end
  end

  // Stage 2: magnitudes and signs
  front_t front_d [0:tsn_pkg::FRONT_DLY];
  always_ff @(posedge clk) begin
    if (en) begin
      front_d[0].sx   <= x1_r[CW-1];
      front_d[0].sa   <= a1_r[CW];
      front_d[0].sz   <= z1_r[CW-1];
      front_d[0].last <= last1_r;
      front_d[0].ax   <= x1_r[CW-1] ? CW'(-x1_r) : CW'(x1_r);
      front_d[0].aa   <= a1_r[CW] ? (CW+1)'(-a1_r) : (CW+1)'(a1_r);
      front_d[0].az   <= z1_r[CW-1] ? CW'(-z1_r) : CW'(z1_r);
      front_d[0].k    <= k1_r;
      for (int i = 1; i <= tsn_pkg::FRONT_DLY; i++) front_d[i] <= front_d[i-1];
    end
  end

  // Stages 3-4: squares of the cross-section offsets
  logic [PW-1:0] a2, z2;
  tsn_mul u_mul_a2 (.clk, .en, .a_i(MW'(front_d[0].aa)), .b_i(MW'(front_d[0].aa)), .prod_o(a2));
  tsn_mul u_mul_z2 (.clk, .en, .a_i(MW'(front_d[0].az)), .b_i(MW'(front_d[0].az)), .prod_o(z2));

  // Stage 5: radicand of the tube distance
  logic [97:0] rad5_r;
  always_ff @(posedge clk) begin
    if (en) rad5_r <= a2[97:0] + z2[97:0];
  end

  // Square root chain for the tube distance r
  logic [tsn_pkg::RAD_W-1:0]  sq1_rad  [0:tsn_pkg::SQ1_STEPS];
  logic [tsn_pkg::ROOT_W-1:0] sq1_root [0:tsn_pkg::SQ1_STEPS];
  logic [tsn_pkg::REM_W-1:0]  sq1_rem  [0:tsn_pkg::SQ1_STEPS];
  assign sq1_rad[0]  = {rad5_r, 30'd0};
  assign sq1_root[0] = '0;
  assign sq1_rem[0]  = '0;
  for (genvar j = 0; j < tsn_pkg::SQ1_STEPS; j++) begin : g_sq1
    tsn_sqrt_cell u_cell (
      .clk, .en,
      .rad_i(sq1_rad[j]), .root_i(sq1_root[j]), .rem_i(sq1_rem[j]),
      .rad_o(sq1_rad[j+1]), .root_o(sq1_root[j+1]), .rem_o(sq1_rem[j+1])
    );
  end

  // Stages 55-56: m = r - (R - rho) and its magnitude
  logic [CW:0]          r55_r, r56_r;
  logic signed [CW+2:0] m55_r;
  logic [CW+1:0]        am56_r;
  logic                 rz55_r, rz56_r, nm56_r;
  front_t               f55_r, f56_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r55_r  <= sq1_root[tsn_pkg::SQ1_STEPS][CW:0];
      m55_r  <= $signed({2'b00, sq1_root[tsn_pkg::SQ1_STEPS][CW:0]})
              - $signed({{2{front_d[tsn_pkg::FRONT_DLY].k[CW]}}, front_d[tsn_pkg::FRONT_DLY].k});
      rz55_r <= (sq1_root[tsn_pkg::SQ1_STEPS] == '0);
      f55_r  <= front_d[tsn_pkg::FRONT_DLY];
      r56_r  <= r55_r;
      am56_r <= m55_r[CW+2] ? (CW+2)'(-m55_r) : (CW+2)'(m55_r);
      nm56_r <= m55_r[CW+2];
      rz56_r <= rz55_r;
      f56_r  <= f55_r;
    end
  end

  // Stages 57-58: scaled normal components
  logic [PW-1:0] cp, cq, cs;
  tsn_mul u_mul_cp (.clk, .en, .a_i(MW'(f56_r.ax)), .b_i(MW'(r56_r)), .prod_o(cp));
  tsn_mul u_mul_cq (.clk, .en, .a_i(MW'(f56_r.aa)), .b_i(MW'(am56_r)), .prod_o(cq));
  tsn_mul u_mul_cs (.clk, .en, .a_i(MW'(f56_r.az)), .b_i(MW'(am56_r)), .prod_o(cs));

  mid_t mid56, mid57_r, mid58_r, mid59_r;
  assign mid56 = '{sx: f56_r.sx, sa: f56_r.sa, sz: f56_r.sz, nm: nm56_r,
                   last: f56_r.last, deg: rz56_r};

  // Stage 59: common shift from the leading one
  logic [98:0] orv;
  logic [5:0]  sh;
  always_comb begin
    orv = cp[98:0] | cq[98:0] | cs[98:0];
    sh  = '0;
    for (int i = GB; i <= 98; i++) begin
      if (orv[i]) sh = 6'(i - GB + 1);
    end
  end

  logic [98:0] cp59_r, cq59_r, cs59_r;
  logic [5:0]  sh59_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mid57_r <= mid56;
      mid58_r <= mid57_r;
      mid59_r <= mid58_r;
      cp59_r  <= cp[98:0];
      cq59_r  <= cq[98:0];
      cs59_r  <= cs[98:0];
      sh59_r  <= sh;
    end
  end

  // Stage 60 onward: shifted components delayed to the divider
  back_t back_d [0:tsn_pkg::BACK_DLY];
  logic [98:0] ps, qs, ss;
  assign ps = cp59_r >> sh59_r;
  assign qs = cq59_r >> sh59_r;
  assign ss = cs59_r >> sh59_r;
  always_ff @(posedge clk) begin
    if (en) begin
      back_d[0].p   <= ps[GB-1:0];
      back_d[0].q   <= qs[GB-1:0];
      back_d[0].s   <= ss[GB-1:0];
      back_d[0].mid <= mid59_r;
      for (int i = 1; i <= tsn_pkg::BACK_DLY; i++) back_d[i] <= back_d[i-1];
    end
  end

  // Stages 61-62: squares of the shifted components
  logic [PW-1:0] p2, q2, s2;
  tsn_mul u_mul_p2 (.clk, .en, .a_i(MW'(back_d[0].p)), .b_i(MW'(back_d[0].p)), .prod_o(p2));
  tsn_mul u_mul_q2 (.clk, .en, .a_i(MW'(back_d[0].q)), .b_i(MW'(back_d[0].q)), .prod_o(q2));
  tsn_mul u_mul_s2 (.clk, .en, .a_i(MW'(back_d[0].s)), .b_i(MW'(back_d[0].s)), .prod_o(s2));

  // Stage 63: squared length
  logic [125:0] sum63_r;
  always_ff @(posedge clk) begin
    if (en) sum63_r <= p2[125:0] + q2[125:0] + s2[125:0];
  end

  // Square root chain for the vector length L
  logic [tsn_pkg::RAD_W-1:0]  sq2_rad  [0:tsn_pkg::SQ2_STEPS];
  logic [tsn_pkg::ROOT_W-1:0] sq2_root [0:tsn_pkg::SQ2_STEPS];
  logic [tsn_pkg::REM_W-1:0]  sq2_rem  [0:tsn_pkg::SQ2_STEPS];
  assign sq2_rad[0]  = {sum63_r, 2'b00};
  assign sq2_root[0] = '0;
  assign sq2_rem[0]  = '0;
  for (genvar j = 0; j < tsn_pkg::SQ2_STEPS; j++) begin : g_sq2
    tsn_sqrt_cell u_cell (
      .clk, .en,
      .rad_i(sq2_rad[j]), .root_i(sq2_root[j]), .rem_i(sq2_rem[j]),
      .rad_o(sq2_rad[j+1]), .root_o(sq2_root[j+1]), .rem_o(sq2_rem[j+1])
    );
  end

  logic [tsn_pkg::DEN_W-1:0] len;
  assign len = sq2_root[tsn_pkg::SQ2_STEPS][tsn_pkg::DEN_W-1:0];

  // Divider chains, one per component
  logic [tsn_pkg::DIVR_W-1:0] dv_rem [0:2][0:tsn_pkg::DIV_STEPS];
  logic [tsn_pkg::DEN_W-1:0]  dv_den [0:2][0:tsn_pkg::DIV_STEPS];
  logic [QW-1:0]              dv_quo [0:2][0:tsn_pkg::DIV_STEPS];
  assign dv_rem[0][0] = tsn_pkg::DIVR_W'(back_d[tsn_pkg::BACK_DLY].p);
  assign dv_rem[1][0] = tsn_pkg::DIVR_W'(back_d[tsn_pkg::BACK_DLY].q);
  assign dv_rem[2][0] = tsn_pkg::DIVR_W'(back_d[tsn_pkg::BACK_DLY].s);
  for (genvar c = 0; c < 3; c++) begin : g_div
    assign dv_den[c][0] = len;
    assign dv_quo[c][0] = '0;
    for (genvar j = 0; j < tsn_pkg::DIV_STEPS; j++) begin : g_cell
      tsn_div_cell u_cell (
        .clk, .en,
        .rem_i(dv_rem[c][j]), .den_i(dv_den[c][j]), .quo_i(dv_quo[c][j]),
        .rem_o(dv_rem[c][j+1]), .den_o(dv_den[c][j+1]), .quo_o(dv_quo[c][j+1])
      );
    end
  end

  // Flag a zero length as degenerate
  mid_t fin_in;
  always_comb begin
    fin_in     = back_d[tsn_pkg::BACK_DLY].mid;
    fin_in.deg = back_d[tsn_pkg::BACK_DLY].mid.deg || (len == '0);
  end

  // Delay signs and flags alongside the dividers
  mid_t fin_d [0:tsn_pkg::DIV_STEPS-1];
  always_ff @(posedge clk) begin
    if (en) begin
      fin_d[0] <= fin_in;
      for (int i = 1; i < tsn_pkg::DIV_STEPS; i++) fin_d[i] <= fin_d[i-1];
    end
  end

  // Final stage: apply signs, negate, zero on degenerate points
  mid_t          fm;
  logic [NW-1:0] qx, qy, qz;
  assign fm = fin_d[tsn_pkg::DIV_STEPS-1];
  assign qx = NW'(dv_quo[0][tsn_pkg::DIV_STEPS]);
  assign qy = NW'(dv_quo[1][tsn_pkg::DIV_STEPS]);
  assign qz = NW'(dv_quo[2][tsn_pkg::DIV_STEPS]);
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.nx   <= fm.deg ? '0 : (fm.sx ? qx : -qx);
      res_r.ny   <= fm.deg ? '0 : ((fm.sa ^ fm.nm) ? qy : -qy);
      res_r.nz   <= fm.deg ? '0 : ((fm.sz ^ fm.nm) ? qz : -qz);
      res_r.deg  <= fm.deg;
      res_r.last <= fm.last;
    end
  end

  // Output register with skid stage
  logic out_fire, tail_v;
  assign out_fire = out_v_r && out_tready;
  assign tail_v   = vld_r[tsn_pkg::PIPE_DEPTH];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        out_r    <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (tail_v) begin
      if (!out_v_r || out_fire) begin
        out_r   <= res_r;
        out_v_r <= 1'b1;
      end else begin
        skid_r   <= res_r;
        skid_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.nz, out_r.ny, out_r.nx};
  assign out_tuser  = out_r.deg;
  assign out_tlast  = out_r.last;

  // Checks
  `TSN_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r, "skid holds data with empty output")
  `TSN_ASSERT_IMP(a_deg_zero, out_v_r && out_r.deg, out_tdata == '0, "degenerate result not zero")
  `TSN_ASSERT_IMP(a_unit_range, out_v_r && !out_r.deg,
    ($signed(out_r.nx) <= 32'sd1073741824) && ($signed(out_r.nx) >= -32'sd1073741824),
    "normal x outside unit range")
  `TSN_ASSERT_NXT(a_skid_freeze, skid_v_r && !out_fire, skid_v_r, "skid dropped a result")

endmodule
`default_nettype wire
